// File: hdl/modular_exponentiation_core_defines.svh
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MEXP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mexp_pkg.sv
// Package for the modular exponentiation core: defaults and operation codes.
`default_nettype none

package mexp_pkg;

  // Default operand width and modulus after reset.
  localparam int          OPERAND_WIDTH_DEF = 31;
  localparam logic [63:0] MODULUS_RESET     = 64'd65537;

  // Operation codes.
  localparam logic OP_POWER   = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

endpackage

`default_nettype wire

// File: hdl/modular_exponentiation_core.sv
// Modular exponentiation core: square-and-multiply over a shared modular step unit.
//
//  channel  | ports                                     | handshake
//  ---------+-------------------------------------------+---------------------------
//  input    | in_operation, in_base, in_exponent        | start & !busy
//  result   | out_result                                | out_valid, one-cycle strobe
//  config   | cfg_data (modulus)                        | cfg_valid & cfg_ready
//
// One word runs setup and base reduction, then, for each exponent bit up to the highest
// set one, bit control, a multiply when the bit is set, and a squaring.
// Every reduction, multiply and squaring runs on the one shared double-and-add modular step, one bit a cycle.
// A modulus below two returns 0 in the cycle after start.
// Synchronous active-low reset clears control and loads the modulus reset value.
// The result cannot be stalled; the next word is taken while a result is shown.
`default_nettype none
`include "modular_exponentiation_core_defines.svh"

module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int W = OPERAND_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire logic         in_operation,
  input  wire logic [W-1:0] in_base,
  input  wire logic [W-1:0] in_exponent,
  output logic              out_valid,
  output logic [W-1:0]      out_result,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [W-1:0] cfg_data
);

  localparam int CW = $clog2(W);
  localparam int XW = W + 2;

  // Sequencer codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_EXP  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  mod_r, mod_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  sq_r, sq_nxt;
  logic [W-1:0]  exp_r, exp_nxt;
  logic [W-1:0]  prod_r, prod_nxt;
  logic [W-1:0]  mplr_r, mplr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_result_r, out_result_nxt;

  logic [XW-1:0] addend;
  logic [XW-1:0] step_sum;
  logic [XW-1:0] mod1;
  logic [XW-1:0] mod2;
  logic [XW-1:0] step_red;
  logic [W-1:0]  step_out;
  logic          accept;

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = !busy;
  assign accept     = start && !busy;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // Shared step: 2*p + addend reduced below the modulus (value stays below 3m).
  always_comb begin
    if (state_r == S_RED) begin
      addend = {{(XW-1){1'b0}}, mplr_r[W-1]};
    end else begin
      addend = mplr_r[W-1] ? {2'b00, sq_r} : '0;
    end
    step_sum = {1'b0, prod_r, 1'b0} + addend;
    mod1     = {2'b00, mod_r};
    mod2     = {1'b0, mod_r, 1'b0};
    priority if (step_sum >= mod2) begin
      step_red = step_sum - mod2;
    end else if (step_sum >= mod1) begin
      step_red = step_sum - mod1;
    end else begin
      step_red = step_sum;
    end
    step_out = step_red[W-1:0];
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    mod_nxt        = mod_r;
    acc_nxt        = acc_r;
    sq_nxt         = sq_r;
    exp_nxt        = exp_r;
    prod_nxt       = prod_r;
    mplr_nxt       = mplr_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;

    // Take a modulus word while idle.
    if (cfg_valid && cfg_ready) begin
      mod_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (mod_r < W'(2)) begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = '0;
          end else begin
            state_nxt = S_RED;
            cnt_nxt   = CW'(W - 1);
            prod_nxt  = '0;
            mplr_nxt  = in_base;
            acc_nxt   = W'(1);
            exp_nxt   = (in_operation == OP_INVERSE) ? (mod_r - W'(2)) : in_exponent;
          end
        end
      end
      S_RED, S_MUL, S_SQR: begin
        // Advance one multiplier bit, MSB first.
        prod_nxt = step_out;
        mplr_nxt = {mplr_r[W-2:0], 1'b0};
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          unique case (state_r)
            S_RED: begin
              sq_nxt    = step_out;
              state_nxt = S_EXP;
            end
            S_MUL: begin
              acc_nxt   = step_out;
              prod_nxt  = '0;
              mplr_nxt  = sq_r;
              cnt_nxt   = CW'(W - 1);
              state_nxt = S_SQR;
            end
            default: begin
              sq_nxt    = step_out;
              exp_nxt   = {1'b0, exp_r[W-1:1]};
              state_nxt = S_EXP;
            end
          endcase
        end
      end
      S_EXP: begin
        // Drop to idle once no exponent bits remain.
        prod_nxt = '0;
        cnt_nxt  = CW'(W - 1);
        if (exp_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = acc_r;
          state_nxt      = S_IDLE;
        end else if (exp_r[0]) begin
          mplr_nxt  = acc_r;
          state_nxt = S_MUL;
        end else begin
          mplr_nxt  = sq_r;
          state_nxt = S_SQR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      mod_r       <= MODULUS_RESET[W-1:0];
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      mod_r       <= mod_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    sq_r         <= sq_nxt;
    exp_r        <= exp_nxt;
    prod_r       <= prod_nxt;
    mplr_r       <= mplr_nxt;
    out_result_r <= out_result_nxt;
  end

  `MEXP_ASSERT_SAME(a_partial_reduced, clk, rst_n,
    (state_r == S_RED || state_r == S_MUL || state_r == S_SQR), (prod_r < mod_r),
    "partial product not reduced below modulus")
  `MEXP_ASSERT_SAME(a_result_reduced, clk, rst_n,
    (out_valid_r && mod_r >= W'(2)), (out_result_r < mod_r),
    "result not reduced below modulus")
  `MEXP_ASSERT_SAME(a_no_strobe_busy, clk, rst_n,
    busy, !out_valid_r,
    "result strobe while a word is in progress")
  `MEXP_ASSERT_NEXT(a_start_progress, clk, rst_n,
    accept, (busy || out_valid_r),
    "accepted word neither started nor answered")

endmodule

`default_nettype wire

// File: verif/modular_exponentiation_core_test.sv
// Self-checking testbench for the modular exponentiation core: directed and random words.
`timescale 1ns / 1ps

module modular_exponentiation_core_test;
  import mexp_pkg::*;

  localparam int W = OPERAND_WIDTH_DEF;
  localparam logic [W-1:0] OPERAND_MAX = {W{1'b1}};
  // Slowest legal run is roughly 320 words of the longest kind; allow several times that.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int END_WAIT = 2100;

  typedef struct packed {
    logic         op;
    logic [W-1:0] base;
    logic [W-1:0] exponent;
  } mexp_word_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic         in_operation = 1'b0;
  logic [W-1:0] in_base = '0;
  logic [W-1:0] in_exponent = '0;
  logic         out_valid;
  logic [W-1:0] out_result;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [W-1:0] cfg_data = '0;

  mexp_word_t   pending_words[$];
  logic [W-1:0] expected_powers[$];
  logic [W-1:0] modulus_shadow = W'(MODULUS_RESET);
  int           sender_idle_pct = 7;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  modular_exponentiation_core #(.W(W)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_base      (in_base),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_result   (out_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Square-and-multiply from the low exponent bit up; products fit in 2W bits.
  function automatic logic [W-1:0] modpow_expected(logic op, logic [W-1:0] b,
                                                   logic [W-1:0] e, logic [W-1:0] m);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] sq;
    logic [2*W-1:0] m_wide;
    logic [W-1:0]   k;
    if (m < 2) begin
      return '0;
    end
    m_wide = {{W{1'b0}}, m};
    // Fermat inverse: raise to modulus minus two, exponent field ignored
    k = (op == OP_INVERSE) ? m - W'(2) : e;
    acc = (2*W)'(1);
    sq = {{W{1'b0}}, b} % m_wide;
    for (int i = 0; i < W; i++) begin
      if (k[i]) acc = (acc * sq) % m_wide;
      sq = (sq * sq) % m_wide;
    end
    return acc[W-1:0];
  endfunction

  // Drive words from the pending queue; record the expected power at each accepted word.
  always @(posedge clk) begin : drive_words
    mexp_word_t next_word;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_powers.insert(expected_powers.size(),
                               modpow_expected(in_operation, in_base, in_exponent,
                                               modulus_shadow));
      end
      if (!start || !busy) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_word = pending_words.pop_front();
          start <= 1'b1;
          in_operation <= next_word.op;
          in_base <= next_word.base;
          in_exponent <= next_word.exponent;
        end else begin
          // idle: scramble the fields, the core must ignore them
          start <= 1'b0;
          in_operation <= 1'($urandom_range(1));
          in_base <= W'($urandom);
          in_exponent <= W'($urandom);
        end
      end
    end
  end

  // Check every result strobe against the oldest expected power.
  always @(posedge clk) begin : check_results
    logic [W-1:0] want;
    if (rst_n && out_valid) begin
      if (expected_powers.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual %0d", $time, out_result);
      end else begin
        want = expected_powers.pop_front();
        if (out_result !== want) begin
          mismatch_count++;
          $display("%0t: result mismatch: expected %0d, actual %0d", $time, want, out_result);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_powers.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic queue_word(logic op, logic [W-1:0] b, logic [W-1:0] e);
    mexp_word_t w;
    w = '{op: op, base: b, exponent: e};
    pending_words.insert(pending_words.size(), w);
  endtask

  // Hold off until every queued word has been taken and answered.
  task automatic drain_results();
    while (pending_words.size() != 0 || start || expected_powers.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_modulus(logic [W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= W'($urandom);
    modulus_shadow = value;
    @(negedge clk);
  endtask

  function automatic logic [W-1:0] pick_modulus();
    logic [W-1:0] primes[8];
    primes = '{W'(2), W'(3), W'(5), W'(251), W'(65537), W'(998244353), W'(1000000007),
               OPERAND_MAX};
    case ($urandom_range(4))
      0, 3:    return primes[$urandom_range(7)];
      1:       return W'($urandom_range(32'h7fff_ffff, 2));
      2:       return W'($urandom_range(300, 2));
      default: return OPERAND_MAX;
    endcase
  endfunction

  // Random word: mostly power, with bases near the modulus and exponents of mixed length.
  task automatic queue_random_word(logic [W-1:0] m);
    logic         op;
    logic [W-1:0] b;
    logic [31:0]  mask;
    longint       mult;
    op = ($urandom_range(3) == 0) ? OP_INVERSE : OP_POWER;
    case ($urandom_range(7))
      0:       b = '0;
      1:       b = OPERAND_MAX;
      2:       b = W'($urandom_range(15));
      3:       b = m - W'(1);
      4: begin
        mult = longint'(m) * longint'($urandom_range(3, 1));
        b = (mult > longint'(OPERAND_MAX)) ? m : W'(mult);
      end
      default: b = W'($urandom);
    endcase
    mask = (32'd1 << $urandom_range(W)) - 32'd1;
    queue_word(op, b, W'($urandom & mask));
  endtask

  initial begin
    int idle_by_seg[3];
    idle_by_seg = '{7, 46, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset modulus
    queue_word(OP_POWER, '0, '0);
    queue_word(OP_POWER, '0, W'(5));
    queue_word(OP_POWER, W'(3), '0);
    queue_word(OP_POWER, OPERAND_MAX, OPERAND_MAX);
    queue_word(OP_POWER, OPERAND_MAX, W'(1));
    queue_word(OP_POWER, W'(2), W'(16));
    queue_word(OP_POWER, W'(65536), W'(1) << (W - 1));
    queue_word(OP_INVERSE, W'(3), '0);
    queue_word(OP_INVERSE, W'(65537), W'(9));
    queue_word(OP_INVERSE, '0, '0);
    queue_word(OP_INVERSE, OPERAND_MAX, OPERAND_MAX);
    drain_results();

    // Smallest prime: inverse of a multiple reduces to exponent zero
    write_modulus(W'(2));
    queue_word(OP_INVERSE, W'(4), W'(7));
    queue_word(OP_POWER, W'(3), OPERAND_MAX);
    drain_results();

    // Largest modulus
    write_modulus(OPERAND_MAX);
    queue_word(OP_INVERSE, W'(2), '0);
    queue_word(OP_POWER, OPERAND_MAX, W'(12345));
    queue_word(OP_POWER, OPERAND_MAX - W'(1), OPERAND_MAX);
    drain_results();

    // Composite modulus with inverse is checked against the Fermat power
    write_modulus(W'(1000000));
    queue_word(OP_INVERSE, W'(7), '0);
    queue_word(OP_INVERSE, W'(10), '0);
    drain_results();

    // Modulus one and zero answer 0
    write_modulus(W'(1));
    queue_word(OP_POWER, W'(5), W'(3));
    queue_word(OP_INVERSE, W'(7), '0);
    drain_results();
    write_modulus('0);
    queue_word(OP_POWER, '0, '0);
    queue_word(OP_INVERSE, OPERAND_MAX, OPERAND_MAX);
    drain_results();

    // Random words: three idle profiles, four moduli each, draining between moduli
    for (int seg = 0; seg < 3; seg++) begin
      sender_idle_pct = idle_by_seg[seg];
      for (int sub = 0; sub < 4; sub++) begin
        write_modulus(pick_modulus());
        for (int n = 0; n < 24; n++) queue_random_word(modulus_shadow);
        drain_results();
      end
    end

    repeat (END_WAIT) @(negedge clk);
    if (mismatch_count == 0 && expected_powers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
